// ===== hw/rtl/pfsse_pkg.sv =====
package pfsse_pkg;

    // polynomial size and register file
    localparam int TERM_COUNT = 4;
    localparam int TERM_W     = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;
    localparam int REG_COUNT  = 4;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);

    // field widths
    localparam int COEFF_W = 24;
    localparam int SAMPLE_W = 24;
    localparam int Q48_W   = 48;
    localparam int TOTAL_W = 64;
    localparam int IN_DATA_W = 2 * SAMPLE_W;

    // Q32.16 limits, held at the 50 bit width of the running sum
    localparam logic signed [49:0] Q48_MAX_EXT = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] Q48_MIN_EXT = -50'sh0_8000_0000_0000;

    // 1.0 in Q.16
    localparam logic [Q48_W-1:0] POWER_ONE = 48'h0000_0001_0000;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_C_HI,
        MUL_C_LO,
        MUL_X_HI,
        MUL_X_LO,
        MUL_S_HH,
        MUL_S_HL,
        MUL_S_LL
    } mul_sel_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_TERM,
        FIN_POWER
    } fin_sel_t;

    typedef struct packed {
        logic              start;
        mul_sel_t          mul_sel;
        logic              hold_hi;
        fin_sel_t          fin_sel;
        logic [TERM_W-1:0] term_idx;
        logic              acc_poly;
        logic              err_sub;
        logic              err_abs;
        logic              sq_hh;
        logic              sq_hl;
        logic              sq_ll;
        logic              sq_fin;
        logic              acc_total;
        logic              emit;
    } pfsse_cmd_t;

    typedef struct packed {
        logic out_busy;
    } pfsse_status_t;

endpackage

// ===== hw/rtl/pfsse_ctrl.sv =====
module pfsse_ctrl
    import pfsse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    input  pfsse_status_t status,
    output pfsse_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_HI,
        S_T_LO,
        S_T_FIN,
        S_T_ACC,
        S_P_LO,
        S_P_FIN,
        S_E_SUB,
        S_E_ABS,
        S_Q_HH,
        S_Q_HL,
        S_Q_LL,
        S_Q_SUM,
        S_Q_FIN,
        S_ACC
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TERM_W-1:0] idx_reg;
    logic [TERM_W-1:0] idx_next;
    logic              last_reg;
    logic              last_next;
    logic              last_term;
    logic              accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign last_term = (idx_reg == TERM_W'(TERM_COUNT - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.mul_sel  = MUL_NONE;
        cmd.fin_sel  = FIN_NONE;
        cmd.term_idx = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    idx_next   = '0;
                    last_next  = in_last;
                    state_next = S_T_HI;
                end
            end
            S_T_HI:
            begin
                cmd.mul_sel = MUL_C_HI;
                state_next  = S_T_LO;
            end
            S_T_LO:
            begin
                cmd.mul_sel = MUL_C_LO;
                cmd.hold_hi = 1'b1;
                state_next  = S_T_FIN;
            end
            S_T_FIN:
            begin
                cmd.fin_sel = FIN_TERM;
                state_next  = S_T_ACC;
            end
            S_T_ACC:
            begin
                cmd.acc_poly = 1'b1;
                if (last_term)
                begin
                    state_next = S_E_SUB;
                end
                else
                begin
                    // next power starts while the term is summed
                    cmd.mul_sel = MUL_X_HI;
                    state_next  = S_P_LO;
                end
            end
            S_P_LO:
            begin
                cmd.mul_sel = MUL_X_LO;
                cmd.hold_hi = 1'b1;
                state_next  = S_P_FIN;
            end
            S_P_FIN:
            begin
                cmd.fin_sel = FIN_POWER;
                idx_next    = idx_reg + 1'b1;
                state_next  = S_T_HI;
            end
            S_E_SUB:
            begin
                cmd.err_sub = 1'b1;
                state_next  = S_E_ABS;
            end
            S_E_ABS:
            begin
                cmd.err_abs = 1'b1;
                state_next  = S_Q_HH;
            end
            S_Q_HH:
            begin
                cmd.mul_sel = MUL_S_HH;
                state_next  = S_Q_HL;
            end
            S_Q_HL:
            begin
                cmd.mul_sel = MUL_S_HL;
                cmd.sq_hh   = 1'b1;
                state_next  = S_Q_LL;
            end
            S_Q_LL:
            begin
                cmd.mul_sel = MUL_S_LL;
                cmd.sq_hl   = 1'b1;
                state_next  = S_Q_SUM;
            end
            S_Q_SUM:
            begin
                cmd.sq_ll  = 1'b1;
                state_next = S_Q_FIN;
            end
            S_Q_FIN:
            begin
                cmd.sq_fin = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // a final point waits here until the output register is free
                if (!(last_reg && status.out_busy))
                begin
                    cmd.acc_total = 1'b1;
                    cmd.emit      = last_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== hw/rtl/pfsse_dpath.sv =====
module pfsse_dpath
    import pfsse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfsse_cmd_t           cmd,
    output pfsse_status_t        status,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TOTAL_W-1:0]   out_total,
    output logic                 out_sat
);

    logic signed [COEFF_W-1:0] coeff_reg [REG_COUNT];

    logic [SAMPLE_W-1:0]        x_mag_reg;
    logic                       x_neg_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic [Q48_W-1:0]           power_mag_reg;
    logic                       power_neg_reg;
    logic [Q48_W-1:0]           term_mag_reg;
    logic                       term_neg_reg;
    logic signed [Q48_W-1:0]    poly_reg;
    logic [47:0]                prod_reg;
    logic [47:0]                part_reg;
    logic signed [49:0]         e_reg;
    logic [49:0]                m_reg;
    logic                       big_reg;
    logic [61:0]                low_reg;
    logic [TOTAL_W-1:0]         sq_reg;
    logic [TOTAL_W-1:0]         sum_reg;
    logic                       seen_reg;
    logic                       out_valid_reg;
    logic [TOTAL_W-1:0]         out_total_reg;
    logic                       out_sat_reg;

    logic signed [COEFF_W-1:0] coeff_sel;
    logic [COEFF_W-1:0]        c_mag;
    logic [23:0]               mul_a;
    logic [23:0]               mul_b;
    logic [19:0]               sq_hi;
    logic [19:0]               sq_lo;
    logic [55:0]               fin_mag;
    logic [55:0]               fin_limit;
    logic                      fin_neg;
    logic                      fin_sat;
    logic [Q48_W-1:0]          fin_res;
    logic signed [49:0]        poly_ext;
    logic signed [49:0]        term_ext;
    logic signed [49:0]        poly_sum;
    logic signed [Q48_W-1:0]   poly_next;
    logic                      poly_sat;
    logic [49:0]               m_next;
    logic [TOTAL_W:0]          total_sum;
    logic [TOTAL_W-1:0]        total_next;
    logic                      total_ovf;
    logic                      seen_next;

    // coefficient for the current term, zero beyond the register file
    always_comb
    begin
        coeff_sel = '0;
        for (int k = 0; k < REG_COUNT; k++)
        begin
            if (int'(cmd.term_idx) == k)
            begin
                coeff_sel = coeff_reg[k];
            end
        end
    end

    assign c_mag = coeff_sel[COEFF_W-1] ? (~coeff_sel + 1'b1) : coeff_sel;
    assign sq_hi = m_reg[39:20];
    assign sq_lo = m_reg[19:0];

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_C_HI:
            begin
                mul_a = c_mag;
                mul_b = power_mag_reg[47:24];
            end
            MUL_C_LO:
            begin
                mul_a = c_mag;
                mul_b = power_mag_reg[23:0];
            end
            MUL_X_HI:
            begin
                mul_a = x_mag_reg;
                mul_b = power_mag_reg[47:24];
            end
            MUL_X_LO:
            begin
                mul_a = x_mag_reg;
                mul_b = power_mag_reg[23:0];
            end
            MUL_S_HH:
            begin
                mul_a = {4'b0, sq_hi};
                mul_b = {4'b0, sq_hi};
            end
            MUL_S_HL:
            begin
                mul_a = {4'b0, sq_hi};
                mul_b = {4'b0, sq_lo};
            end
            MUL_S_LL:
            begin
                mul_a = {4'b0, sq_lo};
                mul_b = {4'b0, sq_lo};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // q16 product from the two partial products, truncated and clamped
    always_comb
    begin
        fin_mag   = {part_reg, 8'b0} + 56'(prod_reg[47:16]);
        fin_neg   = ((cmd.fin_sel == FIN_TERM) ? coeff_sel[COEFF_W-1] : x_neg_reg)
                    ^ power_neg_reg;
        fin_limit = fin_neg ? 56'h80_0000_0000_00 : 56'h7F_FFFF_FFFF_FF;
        fin_sat   = (fin_mag > fin_limit);
        fin_res   = fin_sat ? fin_limit[Q48_W-1:0] : fin_mag[Q48_W-1:0];
    end

    // running polynomial sum with Q32.16 clamp
    always_comb
    begin
        poly_ext = {{2{poly_reg[Q48_W-1]}}, poly_reg};
        term_ext = $signed({2'b0, term_mag_reg});
        poly_sum = term_neg_reg ? (poly_ext - term_ext) : (poly_ext + term_ext);
        poly_sat = 1'b0;
        poly_next = poly_sum[Q48_W-1:0];
        if (poly_sum > Q48_MAX_EXT)
        begin
            poly_next = Q48_MAX_EXT[Q48_W-1:0];
            poly_sat  = 1'b1;
        end
        else if (poly_sum < Q48_MIN_EXT)
        begin
            poly_next = Q48_MIN_EXT[Q48_W-1:0];
            poly_sat  = 1'b1;
        end
    end

    assign m_next = e_reg[49] ? (~e_reg + 1'b1) : e_reg;

    assign total_sum  = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign total_ovf  = total_sum[TOTAL_W];
    assign total_next = total_ovf ? '1 : total_sum[TOTAL_W-1:0];

    always_comb
    begin
        seen_next = seen_reg;
        if ((cmd.fin_sel != FIN_NONE) && fin_sat)
        begin
            seen_next = 1'b1;
        end
        if (cmd.acc_poly && poly_sat)
        begin
            seen_next = 1'b1;
        end
        if (cmd.sq_fin && big_reg)
        begin
            seen_next = 1'b1;
        end
        if (cmd.acc_total && total_ovf)
        begin
            seen_next = 1'b1;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REG_COUNT; k++)
            begin
                coeff_reg[k] <= '0;
            end
            sum_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                coeff_reg[cfg_index] <= cfg_data;
            end
            if (cmd.acc_total)
            begin
                if (cmd.emit)
                begin
                    sum_reg  <= '0;
                    seen_reg <= 1'b0;
                end
                else
                begin
                    sum_reg  <= total_next;
                    seen_reg <= seen_next;
                end
            end
            else
            begin
                seen_reg <= seen_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_mag_reg     <= in_data[SAMPLE_W-1] ? (~in_data[SAMPLE_W-1:0] + 1'b1)
                                                 : in_data[SAMPLE_W-1:0];
            x_neg_reg     <= in_data[SAMPLE_W-1];
            y_reg         <= in_data[IN_DATA_W-1:SAMPLE_W];
            power_mag_reg <= POWER_ONE;
            power_neg_reg <= 1'b0;
            poly_reg      <= '0;
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.hold_hi)
        begin
            part_reg <= prod_reg;
        end
        if (cmd.fin_sel == FIN_TERM)
        begin
            term_mag_reg <= fin_res;
            term_neg_reg <= fin_neg;
        end
        if (cmd.fin_sel == FIN_POWER)
        begin
            power_mag_reg <= fin_res;
            power_neg_reg <= fin_neg;
        end
        if (cmd.acc_poly)
        begin
            poly_reg <= poly_next;
        end
        if (cmd.err_sub)
        begin
            e_reg <= {{2{poly_reg[Q48_W-1]}}, poly_reg}
                     - {{26{y_reg[SAMPLE_W-1]}}, y_reg};
        end
        if (cmd.err_abs)
        begin
            m_reg   <= m_next;
            big_reg <= |m_next[49:40];
        end
        if (cmd.sq_hh)
        begin
            sq_reg <= {prod_reg[39:0], 24'b0};
        end
        if (cmd.sq_hl)
        begin
            low_reg <= 62'({prod_reg[39:0], 21'b0});
        end
        if (cmd.sq_ll)
        begin
            low_reg <= low_reg + 62'(prod_reg[39:0]);
        end
        if (cmd.sq_fin)
        begin
            // square past 2^64 - 1 when the error reaches 2^40
            sq_reg <= big_reg ? '1 : (sq_reg + 64'(low_reg[61:16]));
        end
        if (cmd.emit)
        begin
            out_total_reg <= total_next;
            out_sat_reg   <= seen_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;
    assign out_sat   = out_sat_reg;

endmodule

// ===== hw/rtl/polynomial_fit_sse_accumulator_unit.sv =====
// one point at a time: a new point is taken only once the last one has finished, since
// the single shared 24x24 multiplier forms each q16 product in two halves and the
// square in three
// a final point waits for a free output register; other points do not
// reset: asynchronous, active low; clears coefficients, running total, saturation flag
// and the output valid
module polynomial_fit_sse_accumulator_unit
    import pfsse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // sample_x, sample_y
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TOTAL_W-1:0]   m_axis_tdata,  // error_total
    output logic                 m_axis_tuser,  // total_saturated
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_data
);

    pfsse_cmd_t    cmd;
    pfsse_status_t status;

    pfsse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfsse_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_total (m_axis_tdata),
        .out_sat   (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/pfsse_checker.sv =====
module pfsse_checker
    import pfsse_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [TOTAL_W-1:0]   m_axis_tdata,
    input logic                 m_axis_tuser
);

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("held result changed");

    // one point at a time: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // a result shows up exactly when the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result raised while point in progress");

    // no result can come right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

endmodule

bind polynomial_fit_sse_accumulator_unit pfsse_checker u_pfsse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
